[hw/rtl/vdrm_pkg.sv]
// ----------------------------------------------------------------------------
// vdrm_pkg
// Shared types and codes of the virtqueue descriptor ring manager.
// ----------------------------------------------------------------------------
`default_nettype none

package vdrm_pkg;

  localparam logic [2:0] OP_ALLOC   = 3'd0;
  localparam logic [2:0] OP_PUBLISH = 3'd1;
  localparam logic [2:0] OP_CHAIN   = 3'd2;
  localparam logic [2:0] OP_POLL    = 3'd3;
  localparam logic [2:0] OP_FREE    = 3'd4;
  localparam logic [2:0] OP_DEVICE  = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_FREE  = 2'd1;
  localparam logic [1:0] ST_REJECTED = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_BUILD = 2'd1;
  localparam logic [1:0] MODE_DROP  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PRE,
    S_DISPATCH,
    S_ALLOC_RES,
    S_CH_LINK,
    S_CH_WR,
    S_POLL_RES,
    S_WALK_RD,
    S_WALK_STEP,
    S_RESULT
  } ctrl_state_t;

  typedef struct packed {
    logic ld_in;
    logic pre;
    logic pop;
    logic alloc_empty;
    logic alloc_set;
    logic publish;
    logic ch_drop;
    logic ch_reject;
    logic ch_link;
    logic ch_wr;
    logic poll_empty;
    logic poll_rd;
    logic poll_set;
    logic walk_init;
    logic walk_rd;
    logic walk_step;
    logic dev_wr;
    logic emit;
  } vdrm_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic [1:0] mode;
    logic       fc_zero;
    logic       clen_bad;
    logic       used_empty;
    logic       ch_close;
    logic       walk_done;
    logic       out_busy;
  } vdrm_sts_t;

endpackage

`default_nettype wire

[hw/rtl/vdrm_ctrl.sv]
// ----------------------------------------------------------------------------
// vdrm_ctrl
// Sequencer that steps each accepted word through its operation.
// ----------------------------------------------------------------------------
`default_nettype none

module vdrm_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire vdrm_pkg::vdrm_sts_t sts,
  output vdrm_pkg::vdrm_cmd_t     cmd
);

  vdrm_pkg::ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vdrm_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      vdrm_pkg::S_IDLE: begin
        if (in_valid) state_nxt = vdrm_pkg::S_PRE;
      end
      vdrm_pkg::S_PRE: state_nxt = vdrm_pkg::S_DISPATCH;
      vdrm_pkg::S_DISPATCH: begin
        case (sts.op)
          vdrm_pkg::OP_ALLOC: begin
            state_nxt = sts.fc_zero ? vdrm_pkg::S_RESULT : vdrm_pkg::S_ALLOC_RES;
          end
          vdrm_pkg::OP_PUBLISH: state_nxt = vdrm_pkg::S_RESULT;
          vdrm_pkg::OP_CHAIN: begin
            if (sts.mode == vdrm_pkg::MODE_DROP) begin
              state_nxt = vdrm_pkg::S_IDLE;
            end else if (sts.mode == vdrm_pkg::MODE_IDLE && sts.clen_bad) begin
              state_nxt = vdrm_pkg::S_RESULT;
            end else begin
              state_nxt = vdrm_pkg::S_CH_LINK;
            end
          end
          vdrm_pkg::OP_POLL: begin
            state_nxt = sts.used_empty ? vdrm_pkg::S_RESULT : vdrm_pkg::S_POLL_RES;
          end
          vdrm_pkg::OP_FREE: state_nxt = vdrm_pkg::S_WALK_RD;
          default: state_nxt = vdrm_pkg::S_IDLE;
        endcase
      end
      vdrm_pkg::S_ALLOC_RES: state_nxt = vdrm_pkg::S_RESULT;
      vdrm_pkg::S_CH_LINK:   state_nxt = vdrm_pkg::S_CH_WR;
      vdrm_pkg::S_CH_WR: begin
        state_nxt = sts.ch_close ? vdrm_pkg::S_RESULT : vdrm_pkg::S_IDLE;
      end
      vdrm_pkg::S_POLL_RES: state_nxt = vdrm_pkg::S_RESULT;
      vdrm_pkg::S_WALK_RD:  state_nxt = vdrm_pkg::S_WALK_STEP;
      vdrm_pkg::S_WALK_STEP: begin
        state_nxt = sts.walk_done ? vdrm_pkg::S_RESULT : vdrm_pkg::S_WALK_RD;
      end
      vdrm_pkg::S_RESULT: begin
        if (!sts.out_busy) state_nxt = vdrm_pkg::S_IDLE;
      end
      default: state_nxt = vdrm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      vdrm_pkg::S_IDLE: begin
        in_ready  = 1'b1;
        cmd.ld_in = in_valid;
      end
      vdrm_pkg::S_PRE: cmd.pre = 1'b1;
      vdrm_pkg::S_DISPATCH: begin
        case (sts.op)
          vdrm_pkg::OP_ALLOC: begin
            cmd.alloc_empty = sts.fc_zero;
            cmd.pop         = !sts.fc_zero;
          end
          vdrm_pkg::OP_PUBLISH: cmd.publish = 1'b1;
          vdrm_pkg::OP_CHAIN: begin
            if (sts.mode == vdrm_pkg::MODE_DROP) begin
              cmd.ch_drop = 1'b1;
            end else if (sts.mode == vdrm_pkg::MODE_IDLE && sts.clen_bad) begin
              cmd.ch_reject = 1'b1;
            end else begin
              cmd.pop = 1'b1;
            end
          end
          vdrm_pkg::OP_POLL: begin
            cmd.poll_empty = sts.used_empty;
            cmd.poll_rd    = !sts.used_empty;
          end
          vdrm_pkg::OP_FREE:   cmd.walk_init = 1'b1;
          vdrm_pkg::OP_DEVICE: cmd.dev_wr    = 1'b1;
          default: ;
        endcase
      end
      vdrm_pkg::S_ALLOC_RES: cmd.alloc_set = 1'b1;
      vdrm_pkg::S_CH_LINK:   cmd.ch_link   = 1'b1;
      vdrm_pkg::S_CH_WR:     cmd.ch_wr     = 1'b1;
      vdrm_pkg::S_POLL_RES:  cmd.poll_set  = 1'b1;
      vdrm_pkg::S_WALK_RD:   cmd.walk_rd   = 1'b1;
      vdrm_pkg::S_WALK_STEP: cmd.walk_step = 1'b1;
      vdrm_pkg::S_RESULT:    cmd.emit      = !sts.out_busy;
      default: ;
    endcase
  end

  a_pop_needs_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.pop && sts.op == vdrm_pkg::OP_ALLOC) |-> !sts.fc_zero)
    else $error("pop issued on an empty free stack");
  a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !sts.out_busy)
    else $error("result emitted over a waiting word");
  a_link_follows_pop: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ch_link |-> $past(cmd.pop))
    else $error("chain link step without a pop");

endmodule

`default_nettype wire

[hw/rtl/vdrm_datapath.sv]
// ----------------------------------------------------------------------------
// vdrm_datapath
// Descriptor table, free stack, used ring, indexes and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module vdrm_datapath #(
  parameter int LG_CAP = 8
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [3:0]          cfg_wdata,
  output logic [3:0]               qlog,
  input  wire logic [2:0]          in_op,
  input  wire logic [7:0]          in_desc_id,
  input  wire logic [63:0]         in_buf_addr,
  input  wire logic [31:0]         in_buf_len,
  input  wire logic                in_write_flag,
  input  wire logic [8:0]          in_chain_len,
  input  wire logic                in_seg_last,
  input  wire vdrm_pkg::vdrm_cmd_t cmd,
  output vdrm_pkg::vdrm_sts_t      sts,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [1:0]               out_status,
  output logic [7:0]               out_result_id,
  output logic [31:0]              out_result_len,
  output logic [15:0]              out_avail_count
);

  function automatic logic [8:0] q_size(input logic [3:0] lg_in);
    logic [3:0] lg;
    lg = lg_in;
    if (lg < 4'd1) lg = 4'd1;
    if (lg > 4'd8) lg = 4'd8;
    if (lg > 4'(LG_CAP)) lg = 4'(LG_CAP);
    return 9'd1 << lg;
  endfunction

  logic [3:0]  qlog_r;
  logic [2:0]  op_r;
  logic [7:0]  id_r;
  logic [63:0] addr_r;
  logic [31:0] len_r;
  logic        w_r;
  logic [8:0]  clen_r;
  logic        last_r;

  logic [8:0]  fc_r;
  logic [15:0] avail_idx_r;
  logic [15:0] used_idx_r;
  logic [15:0] last_used_r;
  logic [1:0]  mode_r;
  logic [7:0]  head_r;
  logic [7:0]  tail_r;
  logic        tail_w_r;
  logic [7:0]  seg_r;
  logic [7:0]  cur_r;
  logic [8:0]  guard_r;

  logic [1:0]  res_status_r;
  logic [7:0]  res_id_r;
  logic [31:0] res_len_r;
  logic        out_valid_r;
  logic [1:0]  out_status_r;
  logic [7:0]  out_id_r;
  logic [31:0] out_len_r;
  logic [15:0] out_avail_r;

  logic [63:0] t_addr_mem [256];
  logic [31:0] t_len_mem  [256];
  logic [1:0]  t_flags_mem[256];
  logic [7:0]  t_link_mem [256];
  logic [255:0] t_vld_r;
  logic [7:0]  stk_mem [256];
  logic [8:0]  stk_lw_r;
  logic [7:0]  u_id_mem [256];
  logic [31:0] u_len_mem[256];

  logic [8:0]  size9;
  logic [7:0]  mask8;
  logic        first;
  logic        ch_close;
  logic        ch_force;
  logic        close_tail;

  logic        tw_ad_en;
  logic        tw_fl_en;
  logic [7:0]  tw_idx;
  logic [1:0]  tw_flags;
  logic [7:0]  tw_link;
  logic        stk_rd_en;
  logic [7:0]  stk_rd_idx;
  logic [7:0]  stk_rd_q_r;
  logic [7:0]  stk_rd_idx_r;
  logic        stk_rd_vld_r;
  logic [7:0]  stk_rdata;
  logic        stk_push;
  logic [1:0]  t_flags_q_r;
  logic [7:0]  t_link_q_r;
  logic        t_q_vld_r;
  logic [1:0]  t_flags_rd;
  logic [7:0]  t_link_rd;
  logic [7:0]  u_id_q_r;
  logic [31:0] u_len_q_r;
  logic [8:0]  guard_inc;

  // A stack entry holds a pushed id only at or above the lowest free count
  // seen so far; below that mark it still holds its own index.
  assign size9      = q_size(qlog_r);
  assign mask8      = 8'(size9 - 9'd1);
  assign first      = (mode_r == vdrm_pkg::MODE_IDLE);
  assign ch_close   = last_r || (first && clen_r == 9'd1);
  assign ch_force   = !ch_close && (fc_r == 9'd0);
  assign close_tail = cmd.pre && op_r != vdrm_pkg::OP_CHAIN
                      && mode_r == vdrm_pkg::MODE_BUILD;
  assign stk_rdata  = stk_rd_vld_r ? stk_rd_q_r : stk_rd_idx_r;
  assign t_flags_rd = t_q_vld_r ? t_flags_q_r : 2'b00;
  assign t_link_rd  = t_q_vld_r ? t_link_q_r : 8'd0;
  assign stk_push   = cmd.walk_step && ({1'b0, cur_r} < size9) && (fc_r < size9);
  assign guard_inc  = guard_r + 9'd1;

  always_comb begin
    tw_ad_en = cmd.publish || cmd.ch_wr;
    tw_fl_en = tw_ad_en || close_tail;
    tw_idx   = cmd.publish ? id_r : (cmd.ch_wr ? seg_r : tail_r);
    tw_flags = {w_r, 1'b0};
    tw_link  = 8'd0;
    if (close_tail) begin
      tw_flags = {tail_w_r, 1'b0};
    end else if (cmd.ch_wr && !(ch_close || ch_force)) begin
      tw_flags = {w_r, 1'b1};
      tw_link  = stk_rdata;
    end
    stk_rd_en  = cmd.pop || cmd.ch_link;
    stk_rd_idx = 8'(fc_r - 9'd1);
  end

  always_ff @(posedge clk) begin
    if (tw_ad_en) begin
      t_addr_mem[tw_idx] <= addr_r;
      t_len_mem[tw_idx]  <= len_r;
    end
    if (tw_fl_en) begin
      t_flags_mem[tw_idx] <= tw_flags;
      t_link_mem[tw_idx]  <= tw_link;
    end
    if (cmd.walk_rd) begin
      t_flags_q_r <= t_flags_mem[cur_r];
      t_link_q_r  <= t_link_mem[cur_r];
    end
  end

  always_ff @(posedge clk) begin
    if (stk_push) begin
      stk_mem[fc_r[7:0]] <= cur_r;
    end
    if (stk_rd_en) begin
      stk_rd_q_r   <= stk_mem[stk_rd_idx];
      stk_rd_idx_r <= stk_rd_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.dev_wr) begin
      u_id_mem[used_idx_r[7:0] & mask8]  <= id_r;
      u_len_mem[used_idx_r[7:0] & mask8] <= len_r;
    end
    if (cmd.poll_rd) begin
      u_id_q_r  <= u_id_mem[last_used_r[7:0] & mask8];
      u_len_q_r <= u_len_mem[last_used_r[7:0] & mask8];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      op_r   <= in_op;
      id_r   <= in_desc_id;
      addr_r <= in_buf_addr;
      len_r  <= in_buf_len;
      w_r    <= in_write_flag;
      clen_r <= in_chain_len;
      last_r <= in_seg_last;
    end
    if (cmd.ch_link) seg_r <= stk_rdata;
    if (cmd.walk_init) cur_r <= id_r;
    else if (cmd.walk_step) cur_r <= t_link_rd;
    if (cmd.alloc_empty || cmd.publish || cmd.ch_reject || cmd.poll_empty
        || cmd.walk_init || cmd.alloc_set || cmd.poll_set || cmd.ch_wr) begin
      res_status_r <= vdrm_pkg::ST_OK;
      res_id_r     <= 8'd0;
      res_len_r    <= 32'd0;
      if (cmd.alloc_empty) res_status_r <= vdrm_pkg::ST_NO_FREE;
      if (cmd.ch_reject)   res_status_r <= vdrm_pkg::ST_REJECTED;
      if (cmd.poll_empty)  res_status_r <= vdrm_pkg::ST_EMPTY;
      if (cmd.publish || cmd.walk_init) res_id_r <= id_r;
      if (cmd.alloc_set) res_id_r <= stk_rdata;
      if (cmd.ch_wr) res_id_r <= first ? seg_r : head_r;
      if (cmd.poll_set) begin
        res_id_r  <= u_id_q_r;
        res_len_r <= u_len_q_r;
      end
    end
    if (cmd.emit) begin
      out_status_r <= res_status_r;
      out_id_r     <= res_id_r;
      out_len_r    <= res_len_r;
      out_avail_r  <= avail_idx_r;
    end
    if (cmd.ch_wr) begin
      tail_r   <= seg_r;
      tail_w_r <= w_r;
      if (first) head_r <= seg_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qlog_r       <= 4'd8;
      out_valid_r  <= 1'b0;
      t_vld_r      <= '0;
      stk_lw_r     <= q_size(4'd8);
      fc_r         <= q_size(4'd8);
      avail_idx_r  <= '0;
      used_idx_r   <= '0;
      last_used_r  <= '0;
      mode_r       <= vdrm_pkg::MODE_IDLE;
      guard_r      <= '0;
      stk_rd_vld_r <= 1'b0;
      t_q_vld_r    <= 1'b0;
    end else if (cfg_we) begin
      qlog_r      <= cfg_wdata;
      t_vld_r     <= '0;
      stk_lw_r    <= q_size(cfg_wdata);
      fc_r        <= q_size(cfg_wdata);
      avail_idx_r <= '0;
      used_idx_r  <= '0;
      last_used_r <= '0;
      mode_r      <= vdrm_pkg::MODE_IDLE;
      guard_r     <= '0;
    end else begin
      if (cmd.emit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (tw_fl_en) t_vld_r[tw_idx] <= 1'b1;
      if (stk_rd_en) stk_rd_vld_r <= ({1'b0, stk_rd_idx} >= stk_lw_r);
      if (cmd.pop && fc_r == stk_lw_r) stk_lw_r <= fc_r - 9'd1;
      if (cmd.walk_rd) t_q_vld_r <= t_vld_r[cur_r];
      if (cmd.pre && op_r != vdrm_pkg::OP_CHAIN) mode_r <= vdrm_pkg::MODE_IDLE;
      if (cmd.ch_drop && last_r) mode_r <= vdrm_pkg::MODE_IDLE;
      if (cmd.ch_reject) mode_r <= last_r ? vdrm_pkg::MODE_IDLE : vdrm_pkg::MODE_DROP;
      if (cmd.ch_wr) begin
        if (ch_force) mode_r <= vdrm_pkg::MODE_DROP;
        else mode_r <= ch_close ? vdrm_pkg::MODE_IDLE : vdrm_pkg::MODE_BUILD;
      end
      if (close_tail || cmd.publish || (cmd.ch_wr && (ch_close || ch_force))) begin
        avail_idx_r <= avail_idx_r + 16'd1;
      end
      if (cmd.pop) fc_r <= fc_r - 9'd1;
      else if (stk_push) fc_r <= fc_r + 9'd1;
      if (cmd.dev_wr) used_idx_r <= used_idx_r + 16'd1;
      if (cmd.poll_rd) last_used_r <= last_used_r + 16'd1;
      if (cmd.walk_init) guard_r <= '0;
      else if (cmd.walk_step) guard_r <= guard_inc;
    end
  end

  assign qlog            = qlog_r;
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_result_id   = out_id_r;
  assign out_result_len  = out_len_r;
  assign out_avail_count = out_avail_r;

  always_comb begin
    sts            = '0;
    sts.op         = op_r;
    sts.mode       = mode_r;
    sts.fc_zero    = (fc_r == 9'd0);
    sts.clen_bad   = (clen_r == 9'd0) || (clen_r > fc_r);
    sts.used_empty = (last_used_r == used_idx_r);
    sts.ch_close   = ch_close || ch_force;
    sts.walk_done  = !t_flags_rd[0] || (guard_inc >= size9);
    sts.out_busy   = out_valid_r && !out_ready;
  end

  a_fc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fc_r <= size9)
    else $error("free count above queue size");
  a_guard_bound: assert property (@(posedge clk) disable iff (!rst_n)
    guard_r <= size9)
    else $error("free walk ran past queue size");
  a_mode_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.pre && op_r != vdrm_pkg::OP_CHAIN && !cfg_we) |=> mode_r == vdrm_pkg::MODE_IDLE)
    else $error("chain mode survived another operation");

endmodule

`default_nettype wire

[hw/rtl/virtqueue_descriptor_ring_manager.sv]
// ----------------------------------------------------------------------------
// virtqueue_descriptor_ring_manager
// Driver side of a split virtqueue: descriptor table, free stack, used ring.
//
//   channel  direction  handshake         payload
//   in       input      in_valid/ready    op, desc_id, buf_addr, buf_len, ...
//   out      output     out_valid/ready   status, result_id, result_len, ...
//   cfg      input      APB write/read    queue_size_log2 at address 0
//
// A word passes the pre and dispatch states and then its own steps; a chain
// segment that links on gives no result. A free walks links in read and step
// states, at most queue-size links, through the table read port.
// Reset restores all state; a configuration write restores the queue state.
// A new word is taken while a result waits in the output register; the
// sequencer stalls only when a second result finds that register still full.
// ----------------------------------------------------------------------------
`default_nettype none

module virtqueue_descriptor_ring_manager #(
  parameter int QUEUE_DEPTH = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_op,
  input  wire logic [7:0]  in_desc_id,
  input  wire logic [63:0] in_buf_addr,
  input  wire logic [31:0] in_buf_len,
  input  wire logic        in_write_flag,
  input  wire logic [8:0]  in_chain_len,
  input  wire logic        in_seg_last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [7:0]       out_result_id,
  output logic [31:0]      out_result_len,
  output logic [15:0]      out_avail_count,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int LG_CAP = (QUEUE_DEPTH >= 256) ? 8 : $clog2(QUEUE_DEPTH + 1) - 1;

  vdrm_pkg::vdrm_cmd_t cmd;
  vdrm_pkg::vdrm_sts_t sts;
  logic [3:0]          qlog;
  logic                cfg_we;

  assign cfg_we = psel && penable && pwrite && (paddr == 2'd0);
  assign pready = 1'b1;
  assign prdata = {28'd0, qlog};

  vdrm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  vdrm_datapath #(
    .LG_CAP (LG_CAP)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (pwdata[3:0]),
    .qlog            (qlog),
    .in_op           (in_op),
    .in_desc_id      (in_desc_id),
    .in_buf_addr     (in_buf_addr),
    .in_buf_len      (in_buf_len),
    .in_write_flag   (in_write_flag),
    .in_chain_len    (in_chain_len),
    .in_seg_last     (in_seg_last),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_result_id   (out_result_id),
    .out_result_len  (out_result_len),
    .out_avail_count (out_avail_count)
  );

endmodule

`default_nettype wire
